// ===== sv/lfrs_pkg.sv =====
`default_nettype none

package lfrs_pkg;

  localparam int LFRS_ROOMS = 16;
  localparam int TIME_W     = 40;
  localparam int CNT_W      = 32;
  localparam int IN_W       = 32;
  localparam int CFG_W      = 5;
  localparam int ROOM_W     = 4;
  localparam int S_DATA_W   = 64;
  localparam int M_DATA_W   = 48;

  localparam logic [CFG_W-1:0]  ROOMS_IN_USE_RST = 5'd2;
  localparam logic [TIME_W-1:0] TIME_MAX         = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX        = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_WRITE,
    ST_COUNT,
    ST_COUNT_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_count;
    logic addr_clr;
    logic write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic at_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/lowest_free_room_scheduler.sv =====
// lowest free room scheduler
// s_* channel: one job per transfer, tdata = start_time[31:0], end_time[63:32].
// m_* channel: one result per job, tdata = room[3:0], finish_time[43:4],
//   busiest_room[47:44].
// cfg_* channel: writes rooms_in_use (5 bits); cfg_ready is always high.
//   write it only while no job is in flight.
// each job scans the active rooms twice through the single-read-port room
// store: once for free times (lowest free room, or earliest to free), then,
// after the chosen room is updated, once more for use counts to find the
// busiest room. a new job is accepted only once the result of the last one
// is loaded into the output register.
// the result sits in an output register; a stalled receiver holds the
// scheduler only at its final step, so the next job is taken and scanned
// while the previous result waits.
// reset clears all room state at once (per-room valid bits), sets
// rooms_in_use to 2 and drops m_tvalid.
`default_nettype none

module lowest_free_room_scheduler #(
  parameter int ROOMS = lfrs_pkg::LFRS_ROOMS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [lfrs_pkg::S_DATA_W-1:0] s_tdata,   // start_time, end_time
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [lfrs_pkg::M_DATA_W-1:0] m_tdata,   // room, finish_time, busiest_room
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [lfrs_pkg::CFG_W-1:0]    cfg_data
);
  import lfrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  lfrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lfrs_datapath #(
    .ROOMS (ROOMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ===== sv/lfrs_ctrl.sv =====
`default_nettype none

module lfrs_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  lfrs_pkg::status_t status,
  output lfrs_pkg::cmd_t    cmd
);
  import lfrs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load     = 1'b1;
          cmd.addr_clr = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.at_last) state_next = ST_SCAN_DRAIN;
      end
      ST_SCAN_DRAIN: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write    = 1'b1;
        cmd.addr_clr = 1'b1;
        state_next   = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_count = 1'b1;
        if (status.at_last) state_next = ST_COUNT_DRAIN;
      end
      ST_COUNT_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold here until the output register can take the result
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lfrs_datapath.sv =====
`default_nettype none

module lfrs_datapath #(
  parameter int ROOMS = lfrs_pkg::LFRS_ROOMS
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [lfrs_pkg::S_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [lfrs_pkg::M_DATA_W-1:0]       m_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [lfrs_pkg::CFG_W-1:0]          cfg_data,
  input  lfrs_pkg::cmd_t                      cmd,
  output lfrs_pkg::status_t                   status
);
  import lfrs_pkg::*;

  localparam int IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;

  logic [CFG_W-1:0]  rooms_in_use;
  logic [IW-1:0]     last_idx;
  logic [IN_W-1:0]   start_time;
  logic [IN_W-1:0]   duration;
  logic [IW-1:0]     addr;

  logic [TIME_W-1:0] ft_mem [ROOMS];
  logic [CNT_W-1:0]  cnt_mem [ROOMS];
  logic [ROOMS-1:0]  entry_valid;

  logic [TIME_W-1:0] ft_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ent_q;
  logic              rd_vld;
  logic              rd_count;
  logic              rd_first;
  logic [IW-1:0]     rd_idx;

  logic              found;
  logic [IW-1:0]     f_idx;
  logic [CNT_W-1:0]  f_cnt;
  logic [IW-1:0]     m_idx;
  logic [TIME_W-1:0] m_ft;
  logic [CNT_W-1:0]  m_cnt;
  logic [IW-1:0]     b_idx;
  logic [CNT_W-1:0]  b_cnt;

  logic [IW-1:0]     res_room;
  logic [TIME_W-1:0] res_finish;

  logic [TIME_W-1:0] eff_ft;
  logic [CNT_W-1:0]  eff_cnt;
  logic              found_cur;
  logic [IW-1:0]     pick;
  logic [TIME_W-1:0] base;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] finish;
  logic [CNT_W-1:0]  cnt_old;
  logic [CNT_W-1:0]  cnt_new;
  logic [IN_W-1:0]   in_start;
  logic [IN_W-1:0]   in_end;

  assign cfg_ready = 1'b1;
  assign in_start  = s_tdata[IN_W-1:0];
  assign in_end    = s_tdata[2*IN_W-1:IN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= ROOMS_IN_USE_RST;
    end else if (cfg_valid) begin
      rooms_in_use <= cfg_data;
    end
  end

  // zero rooms acts as one, too many acts as all of them
  always_comb begin
    if (32'(rooms_in_use) > ROOMS) begin
      last_idx = IW'(ROOMS - 1);
    end else if (rooms_in_use == '0) begin
      last_idx = '0;
    end else begin
      last_idx = IW'(32'(rooms_in_use) - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_time <= in_start;
      duration   <= (in_end > in_start) ? (in_end - in_start) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_clr) begin
      addr <= '0;
    end else if (cmd.rd_en) begin
      addr <= addr + 1'b1;
    end
  end

  // room store, one read port on the scan address, one write port on the pick
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ft_mem[pick]  <= finish;
      cnt_mem[pick] <= cnt_new;
    end
    ft_q  <= ft_mem[addr];
    cnt_q <= cnt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.write) begin
      entry_valid[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
    ent_q    <= entry_valid[addr];
    rd_count <= cmd.rd_count;
    rd_first <= (addr == '0);
    rd_idx   <= addr;
  end

  // never-written rooms read as free at time zero with no uses
  assign eff_ft    = ent_q ? ft_q : '0;
  assign eff_cnt   = ent_q ? cnt_q : '0;
  assign found_cur = rd_first ? 1'b0 : found;

  always_ff @(posedge clk) begin
    if (rd_vld && !rd_count) begin
      found <= found_cur;
      if (!found_cur && (eff_ft <= TIME_W'(start_time))) begin
        found <= 1'b1;
        f_idx <= rd_idx;
        f_cnt <= eff_cnt;
      end
      if (rd_first || (eff_ft < m_ft)) begin
        m_idx <= rd_idx;
        m_ft  <= eff_ft;
        m_cnt <= eff_cnt;
      end
    end
    if (rd_vld && rd_count) begin
      if (rd_first || (eff_cnt > b_cnt)) begin
        b_idx <= rd_idx;
        b_cnt <= eff_cnt;
      end
    end
  end

  always_comb begin
    pick    = found ? f_idx : m_idx;
    base    = found ? TIME_W'(start_time) : m_ft;
    sum     = {1'b0, base} + (TIME_W + 1)'(duration);
    finish  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    cnt_old = found ? f_cnt : m_cnt;
    cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      res_room   <= pick;
      res_finish <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {ROOM_W'(b_idx), res_finish, ROOM_W'(res_room)};
    end
  end

  assign status.at_last  = (addr == last_idx);
  assign status.out_free = !m_tvalid || m_tready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && m_tvalid && !m_tready))
    else $error("result overwritten while a transfer is pending");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (pick <= last_idx))
    else $error("room picked outside the active set");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (addr <= last_idx))
    else $error("scan read outside the active set");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> entry_valid[$past(pick)])
    else $error("written room not marked valid");

endmodule

`default_nettype wire

// ===== tb/lowest_free_room_scheduler_tb.sv =====
`default_nettype none

module lowest_free_room_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * LFRS_ROOMS + 8;

  typedef struct {
    logic [IN_W-1:0] start_time;
    logic [IN_W-1:0] end_time;
  } job_t;

  typedef struct {
    logic [ROOM_W-1:0] room;
    logic [TIME_W-1:0] finish_time;
    logic [ROOM_W-1:0] busiest_room;
  } assignment_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // start_time, end_time
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // room, finish_time, busiest_room
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;

  // scheduler model state
  logic [TIME_W-1:0] room_free_at [LFRS_ROOMS];
  logic [CNT_W-1:0]  room_jobs [LFRS_ROOMS];
  logic [CFG_W-1:0]  rooms_cfg;

  job_t        job_queue [$];
  assignment_t assignments_due [$];
  logic [IN_W-1:0] job_cursor;

  int jobs_queued = 0;
  int jobs_sent = 0;
  int jobs_accepted = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 57;

  lowest_free_room_scheduler #(
    .ROOMS(LFRS_ROOMS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < LFRS_ROOMS; i++) begin
      room_free_at[i] = '0;
      room_jobs[i] = '0;
    end
    rooms_cfg = ROOMS_IN_USE_RST;
  end

  // picks the room for one job and updates free times and use counts
  function automatic assignment_t schedule_job(input logic [IN_W-1:0] start,
                                               input logic [IN_W-1:0] stop);
    logic [IN_W-1:0]   dur;
    logic [TIME_W:0]   finish;
    int                n;
    int                pick;
    int                busiest;
    bit                found;
    assignment_t       a;
    dur = (stop > start) ? stop - start : '0;
    n = (rooms_cfg == 0) ? 1 : ((rooms_cfg > LFRS_ROOMS) ? LFRS_ROOMS : int'(rooms_cfg));
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && room_free_at[i] <= {{(TIME_W-IN_W){1'b0}}, start}) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (found) begin
      finish = {{(TIME_W+1-IN_W){1'b0}}, start} + {{(TIME_W+1-IN_W){1'b0}}, dur};
    end else begin
      // nobody free: wait for the earliest room, lowest index on ties
      pick = 0;
      for (int i = 1; i < n; i++)
        if (room_free_at[i] < room_free_at[pick]) pick = i;
      finish = {1'b0, room_free_at[pick]} + {{(TIME_W+1-IN_W){1'b0}}, dur};
      if (finish > {1'b0, TIME_MAX}) finish = {1'b0, TIME_MAX};
    end
    room_free_at[pick] = finish[TIME_W-1:0];
    if (room_jobs[pick] != COUNT_MAX) room_jobs[pick] = room_jobs[pick] + 1'b1;
    busiest = 0;
    for (int i = 1; i < n; i++)
      if (room_jobs[i] > room_jobs[busiest]) busiest = i;
    a.room = pick[ROOM_W-1:0];
    a.finish_time = finish[TIME_W-1:0];
    a.busiest_room = busiest[ROOM_W-1:0];
    return a;
  endfunction

  task automatic check_field(input string what, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  task automatic queue_job(input logic [IN_W-1:0] start, input logic [IN_W-1:0] stop);
    job_t j;
    j.start_time = start;
    j.end_time = stop;
    job_queue.push_back(j);
    jobs_queued++;
  endtask

  // mostly sorted jobs with random gaps and lengths, some zero-length and some noise
  task automatic queue_random_jobs(input int count, input int max_step, input int max_dur);
    int               kind;
    logic [IN_W:0]    stop;
    logic [IN_W-1:0]  len;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        job_cursor = job_cursor + $urandom_range(0, max_step);
        len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, max_dur);
        stop = {1'b0, job_cursor} + {1'b0, len};
        queue_job(job_cursor, stop[IN_W] ? {IN_W{1'b1}} : stop[IN_W-1:0]);
      end else if (kind < 90) begin
        queue_job(job_cursor, job_cursor - $urandom_range(0, 3));
      end else begin
        queue_job($urandom, $urandom);
      end
    end
  endtask

  // waits until every queued job has produced its result, then lets the block settle
  task automatic drain_jobs();
    do @(negedge clk); while (results_seen != jobs_queued);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rooms(input logic [CFG_W-1:0] value);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rooms, input int count,
                           input int max_step, input int max_dur);
    write_rooms(rooms);
    queue_random_jobs(count, max_step, max_dur);
    drain_jobs();
  endtask

  always @(negedge clk) begin : drive_jobs
    job_t j;
    if (!rst) begin
      // hold the current job until its transfer has happened
      if (!(s_tvalid && jobs_accepted != jobs_sent)) begin
        if (job_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          j = job_queue.pop_front();
          s_tdata <= {j.end_time, j.start_time};
          s_tvalid <= 1'b1;
          jobs_sent <= jobs_sent + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    assignment_t due;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        rooms_cfg = cfg_data;
        cfg_writes <= cfg_writes + 1;
      end
      if (s_tvalid && s_tready) begin
        assignments_due.push_back(schedule_job(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W]));
        jobs_accepted <= jobs_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (assignments_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
          error_count++;
        end else begin
          due = assignments_due.pop_front();
          check_field("room", TIME_W'(due.room), TIME_W'(m_tdata[ROOM_W-1:0]));
          check_field("finish_time", due.finish_time, m_tdata[ROOM_W+TIME_W-1:ROOM_W]);
          check_field("busiest_room", TIME_W'(due.busiest_room),
                      TIME_W'(m_tdata[M_DATA_W-1:ROOM_W+TIME_W]));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d of %0d results seen",
             cycle_count, results_seen, jobs_queued);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run_test
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    job_cursor = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed jobs at the reset room count
    queue_job(32'd0, 32'd0);
    queue_job(32'd0, 32'hFFFF_FFFF);
    queue_job(32'd0, 32'd1);
    queue_job(32'd1, 32'd1);
    queue_job(32'd5, 32'd3);
    queue_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_job(32'hFFFF_FFFF, 32'd0);
    queue_job(32'hAAAA_AAAA, 32'h5555_5555);
    queue_job(32'h5555_5555, 32'hAAAA_AAAA);
    queue_job(32'd10, 32'd20);
    drain_jobs();
    // zero rooms behaves as one
    write_rooms(5'd0);
    queue_job(32'd100, 32'd200);
    queue_job(32'd100, 32'd300);
    queue_job(32'd150, 32'd160);
    drain_jobs();
    // more rooms than exist
    write_rooms(5'd31);
    queue_job(32'd200, 32'd210);
    queue_job(32'd200, 32'd220);
    queue_job(32'd205, 32'd206);
    queue_job(32'd300, 32'd300);
    drain_jobs();
    write_rooms(5'd16);
    queue_job(32'd400, 32'd500);
    queue_job(32'd400, 32'd500);
    queue_job(32'd450, 32'd451);
    queue_job(32'd600, 32'd700);
    drain_jobs();

    job_cursor = 32'd1000;
    run_phase(5'd1, 60, 20, 30);
    run_phase(5'd16, 80, 5, 200);
    run_phase(5'd31, 50, 5, 150);

    send_idle_pct = 57;
    recv_idle_pct = 27;
    // one room with back-to-back full-length jobs drives the free time into saturation
    write_rooms(5'd0);
    repeat (280) begin
      queue_job(job_cursor, 32'hFFFF_FFFF);
      job_cursor = job_cursor + 1'b1;
    end
    drain_jobs();
    // shrink the room set below what was used before
    run_phase(5'd3, 60, 10, 40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(5'd7, 60, 8, 80);
    run_phase(5'd16, 60, 4, 120);
    run_phase(ROOMS_IN_USE_RST, 40, 15, 40);

    if (assignments_due.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, assignments_due.size());
      error_count++;
    end
    $display("%0d jobs scheduled over %0d room-count writes, %0d results compared",
             jobs_accepted, cfg_writes, results_seen);
    $display("room counts 0 to 31 incl. overrange, waits, zero-length jobs, saturated finish");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
